// ===== src/hbridge_current_protection_unit_defines.svh =====
// Assertion macros for the RTL of the H-bridge current protection unit.
// They use the clk and arst_n signals of the module that expands them.
`ifndef HBRIDGE_CURRENT_PROTECTION_UNIT_DEFINES_SVH
`define HBRIDGE_CURRENT_PROTECTION_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define HCP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define HCP_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== src/hcp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcp_pkg
// Types, codes and constants shared by the H-bridge current protection unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcp_pkg;

	localparam int ADC_W     = 12;
	localparam int SUM_W     = 16;
	localparam int RETRY_W   = 8;
	localparam int STATE_W   = 3;
	localparam int LED_W     = 3;
	localparam int OP_W      = 2;

	// Number of readings per averaged evaluation; must be a power of two.
	localparam int SAMPLES   = 16;
	localparam int AVG_SHIFT = $clog2(SAMPLES);
	localparam int IDX_W     = $clog2(SAMPLES + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [RETRY_W-1:0] TRIP_MAX = '1;

	localparam logic [ADC_W-1:0]   OC_LIMIT_RST   = 12'd3686;
	localparam logic [ADC_W-1:0]   SD_LIMIT_RST   = 12'd4090;
	localparam logic [ADC_W-1:0]   WARN_LIMIT_RST = 12'd2764;
	localparam logic [RETRY_W-1:0] RETRY_RST      = 8'd3;
	localparam logic               THERMAL_RST    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OC_LIMIT   = 3'd0,
		CFG_SD_LIMIT   = 3'd1,
		CFG_WARN_LIMIT = 3'd2,
		CFG_RETRY      = 3'd3,
		CFG_THERMAL    = 3'd4
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE  = 2'd0,
		OP_ENABLE  = 2'd1,
		OP_DISABLE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_SAMPLE  = 2'd1,
		CMD_ENABLE  = 2'd2,
		CMD_DISABLE = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		MODE_OFF     = 5'b00001,
		MODE_ON      = 5'b00010,
		MODE_OVER    = 5'b00100,
		MODE_SHUTDN  = 5'b01000,
		MODE_THERMAL = 5'b10000
	} mode_t;

	localparam logic [STATE_W-1:0] ST_OFF     = 3'd0;
	localparam logic [STATE_W-1:0] ST_ON      = 3'd1;
	localparam logic [STATE_W-1:0] ST_OVER    = 3'd2;
	localparam logic [STATE_W-1:0] ST_SHUTDN  = 3'd3;
	localparam logic [STATE_W-1:0] ST_THERMAL = 3'd4;

	typedef enum logic [LED_W-1:0] {
		LED_OFF          = 3'd0,
		LED_GREEN        = 3'd1,
		LED_YELLOW       = 3'd2,
		LED_RED          = 3'd3,
		LED_RED_BLINK    = 3'd4,
		LED_YELLOW_BLINK = 3'd5
	} led_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [ADC_W-1:0] sample;
		logic             warm;
	} item_t;

	typedef struct packed {
		logic [ADC_W-1:0]   oc_limit;
		logic [ADC_W-1:0]   sd_limit;
		logic [ADC_W-1:0]   warn_limit;
		logic [RETRY_W-1:0] retry_limit;
		logic               thermal_en;
	} cfg_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic               enable;
		logic [ADC_W-1:0]   average;
		logic               evaluated;
		led_t               led;
		logic               ev_short;
		logic               ev_shut;
		logic               ev_therm;
	} result_t;

	function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
		logic [STATE_W-1:0] code;
		case (m)
			MODE_ON:      code = ST_ON;
			MODE_OVER:    code = ST_OVER;
			MODE_SHUTDN:  code = ST_SHUTDN;
			MODE_THERMAL: code = ST_THERMAL;
			default:      code = ST_OFF;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ===== src/hcp_front.sv =====
// ----------------------------------------------------------------------------
// hcp_front
// Accepts input transactions and turns the raw op code into a command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcp_front import hcp_pkg::*; (
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [OP_W-1:0]  op,
	input  wire logic [ADC_W-1:0] adc_sample,
	input  wire logic             thermal_warning,
	output logic                  push_valid,
	input  wire logic             push_ready,
	output item_t                 push_item
);

	cmd_t cmd;

	// The unused op code becomes a no-op that still yields a result.
	always_comb begin
		case (op)
			OP_SAMPLE:  cmd = CMD_SAMPLE;
			OP_ENABLE:  cmd = CMD_ENABLE;
			OP_DISABLE: cmd = CMD_DISABLE;
			default:    cmd = CMD_NONE;
		endcase
	end

	assign push_item.cmd    = cmd;
	assign push_item.sample = adc_sample;
	assign push_item.warm   = thermal_warning;
	assign push_valid       = in_valid;
	assign in_ready         = push_ready;

endmodule

`default_nettype wire

// ===== src/hcp_queue.sv =====
// ----------------------------------------------------------------------------
// hcp_queue
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcp_queue import hcp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/hcp_back.sv =====
// ----------------------------------------------------------------------------
// hcp_back
// Executes commands: sample averaging, limit checks, bridge state and LED,
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hbridge_current_protection_unit_defines.svh"

module hcp_back import hcp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  pop_valid,
	output logic       pop_ready,
	input  wire item_t pop_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    result
);

	mode_t              mode_q, mode_d;
	led_t               led_q, led_d, color;
	logic [SUM_W-1:0]   sum_q, sum_d, sum_n;
	logic [IDX_W-1:0]   idx_q, idx_d, idx_n;
	logic [RETRY_W-1:0] trip_q, trip_d;
	logic [ADC_W-1:0]   avg_q, avg_d, avg_n;
	logic               eval;
	logic               changed;
	logic               ev_short, ev_shut, ev_therm;
	logic               pop;
	logic               out_valid_q;
	result_t            res_q;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;

	assign sum_n = sum_q + SUM_W'(pop_item.sample);
	assign idx_n = idx_q + IDX_W'(1);
	assign avg_n = ADC_W'(sum_n >> AVG_SHIFT);

	always_comb begin
		mode_d = mode_q;
		led_d  = led_q;
		sum_d  = sum_q;
		idx_d  = idx_q;
		trip_d = trip_q;
		avg_d  = avg_q;
		eval   = 1'b0;
		color  = LED_GREEN;
		case (pop_item.cmd)
			CMD_ENABLE: begin
				mode_d = MODE_ON;
				led_d  = LED_GREEN;
				sum_d  = '0;
				idx_d  = '0;
			end
			CMD_DISABLE: begin
				mode_d = MODE_OFF;
				led_d  = LED_OFF;
				sum_d  = '0;
				idx_d  = '0;
			end
			CMD_SAMPLE: begin
				if (mode_q != MODE_OFF) begin
					if (idx_n >= IDX_W'(SAMPLES)) begin
						eval  = 1'b1;
						avg_d = avg_n;
						sum_d = '0;
						idx_d = '0;
						if (avg_n >= cfg.sd_limit) begin
							mode_d = MODE_SHUTDN;
							color  = LED_RED_BLINK;
						end else if (avg_n >= cfg.oc_limit) begin
							// Each overcurrent pass counts, saturating at the maximum; the trip uses the old count.
							if (trip_q != TRIP_MAX) begin
								trip_d = trip_q + RETRY_W'(1);
							end
							if (trip_q >= cfg.retry_limit) begin
								mode_d = MODE_OVER;
								color  = LED_RED;
							end
						end else if (cfg.thermal_en && pop_item.warm) begin
							mode_d = MODE_THERMAL;
							color  = LED_YELLOW_BLINK;
						end else if (mode_q != MODE_ON) begin
							mode_d = MODE_ON;
							trip_d = '0;
							color  = (avg_n >= cfg.warn_limit) ? LED_YELLOW : LED_GREEN;
						end
						if (mode_d != mode_q) begin
							led_d = color;
						end
					end else begin
						sum_d = sum_n;
						idx_d = idx_n;
					end
				end
			end
			default: begin
			end
		endcase
		changed  = eval && (mode_d != mode_q);
		ev_short = changed && (mode_q == MODE_OVER || mode_d == MODE_OVER);
		ev_shut  = changed && (mode_q == MODE_SHUTDN || mode_d == MODE_SHUTDN);
		ev_therm = changed && (mode_q == MODE_THERMAL || mode_d == MODE_THERMAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OFF;
			led_q       <= LED_OFF;
			sum_q       <= '0;
			idx_q       <= '0;
			trip_q      <= '0;
			avg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_d;
				led_q       <= led_d;
				sum_q       <= sum_d;
				idx_q       <= idx_d;
				trip_q      <= trip_d;
				avg_q       <= avg_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.state     <= mode_code(mode_d);
			res_q.enable    <= (mode_d == MODE_ON);
			res_q.average   <= avg_d;
			res_q.evaluated <= eval;
			res_q.led       <= led_d;
			res_q.ev_short  <= ev_short;
			res_q.ev_shut   <= ev_shut;
			res_q.ev_therm  <= ev_therm;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

	`HCP_ASSERT_IMPLY(a_event_needs_eval,
		out_valid_q && (res_q.ev_short || res_q.ev_shut || res_q.ev_therm),
		res_q.evaluated, "change event reported without an evaluation")
	`HCP_ASSERT(a_eval_restarts_block, pop && eval |=> idx_q == '0 && sum_q == '0,
		"sample block not restarted after an evaluation")
	`HCP_ASSERT(a_trip_clear_on_return, trip_q != '0 |=> trip_q != '0 || mode_q == MODE_ON,
		"trip counter cleared without a return to on")
	`HCP_ASSERT(a_shutdown_led,
		pop && eval && mode_d == MODE_SHUTDN && mode_q != MODE_SHUTDN |=> led_q == LED_RED_BLINK,
		"entering shutdown did not set the red blink LED")

endmodule

`default_nettype wire

// ===== src/hbridge_current_protection_unit.sv =====
// ----------------------------------------------------------------------------
// hbridge_current_protection_unit
// Current protection monitor for one H-bridge: commands and current samples
// in, bridge state, enable, LED code and change events out.
// ----------------------------------------------------------------------------
// One transaction in gives exactly one result out. The block takes one
// transaction per clock cycle and delivers one result per cycle while
// out_ready stays high; a result passes through the two-entry command queue
// and then the output register, and is held there until it is taken.
// The rate is set by the back end, which updates the bridge state, the
// sample sum and the trip counter once per command. Sixteen samples form
// one averaged evaluation. Write the configuration registers only while no
// transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module hbridge_current_protection_unit import hcp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OP_W-1:0]       op,
	input  wire logic [ADC_W-1:0]      adc_sample,
	input  wire logic                  thermal_warning,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [STATE_W-1:0]         bridge_state,
	output logic                       bridge_enable,
	output logic [ADC_W-1:0]           average_reading,
	output logic                       evaluated,
	output logic [LED_W-1:0]           led_color,
	output logic                       short_event,
	output logic                       shutdown_event,
	output logic                       thermal_event
);

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    pop_valid;
	logic    pop_ready;
	item_t   pop_item;
	result_t result;

	// Writes to an index beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oc_limit    <= OC_LIMIT_RST;
			cfg_q.sd_limit    <= SD_LIMIT_RST;
			cfg_q.warn_limit  <= WARN_LIMIT_RST;
			cfg_q.retry_limit <= RETRY_RST;
			cfg_q.thermal_en  <= THERMAL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OC_LIMIT:   cfg_q.oc_limit    <= cfg_data[ADC_W-1:0];
				CFG_SD_LIMIT:   cfg_q.sd_limit    <= cfg_data[ADC_W-1:0];
				CFG_WARN_LIMIT: cfg_q.warn_limit  <= cfg_data[ADC_W-1:0];
				CFG_RETRY:      cfg_q.retry_limit <= cfg_data[RETRY_W-1:0];
				CFG_THERMAL:    cfg_q.thermal_en  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	hcp_front u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.adc_sample      (adc_sample),
		.thermal_warning (thermal_warning),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_item       (push_item)
	);

	hcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	hcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign bridge_state    = result.state;
	assign bridge_enable   = result.enable;
	assign average_reading = result.average;
	assign evaluated       = result.evaluated;
	assign led_color       = result.led;
	assign short_event     = result.ev_short;
	assign shutdown_event  = result.ev_shut;
	assign thermal_event   = result.ev_therm;

endmodule

`default_nettype wire
